FILE: rtl/phase_angle_level_ramp_control_macros.svh
// ----------------------------------------------------------------------------
// phase_angle_level_ramp_control_macros.svh
// Assertion macros shared by the phase-angle level ramp control RTL.
// ----------------------------------------------------------------------------
`ifndef PHASE_ANGLE_LEVEL_RAMP_CONTROL_MACROS_SVH
`define PHASE_ANGLE_LEVEL_RAMP_CONTROL_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define PALRC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define PALRC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/palrc_pkg.sv
// ----------------------------------------------------------------------------
// palrc_pkg
// Types and constants for the phase-angle level ramp control.
// ----------------------------------------------------------------------------
package palrc_pkg;

    localparam int LEVEL_COUNT_DEF = 5;
    localparam int DELAY_MAX_DEF   = 100;

    localparam int CFG_COUNT  = 5;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 7;

    localparam int FIRE_DELAY_W  = 7;
    localparam int SPEED_LEVEL_W = 3;

    typedef logic [CFG_IDX_W-1:0]  t_cfg_idx;
    typedef logic [CFG_DATA_W-1:0] t_cfg_data;

    localparam t_cfg_data CFG_RESET [CFG_COUNT] = '{
        7'd90, 7'd70, 7'd50, 7'd30, 7'd10
    };

    typedef struct packed {
        logic reset_request;
        logic plus_pin;
        logic minus_pin;
        logic zero_cross;
        logic filter_off;
        logic power_off;
    } t_in;

    typedef struct packed {
        logic                     fire;
        logic [FIRE_DELAY_W-1:0]  fire_delay;
        logic [SPEED_LEVEL_W-1:0] speed_level;
        logic                     level_changed;
    } t_out;

endpackage

FILE: rtl/phase_angle_level_ramp_control.sv
// ----------------------------------------------------------------------------
// phase_angle_level_ramp_control
// Speed level and soft-start firing delay for a triac phase-angle drive.
// One request is taken per clock while the skid stage is empty; its result is
// registered in the output register. A one-entry skid stage takes one more
// request while the output is stalled, so the sustained rate is one request
// per cycle whenever the consumer keeps up. Each request updates the level
// from the button edges (or the stored pin states on a level reset) and, on
// a zero crossing with the filter off and power on, fires and moves the
// delay one percent toward the current level's target. The user writes the
// five per-level targets via the config port only while idle (not enforced).
// ----------------------------------------------------------------------------
module phase_angle_level_ramp_control #(
    parameter int LEVEL_COUNT = palrc_pkg::LEVEL_COUNT_DEF,
    parameter int DELAY_MAX   = palrc_pkg::DELAY_MAX_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  palrc_pkg::t_in       i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output palrc_pkg::t_out      o_out_data,
    input  logic                 i_cfg_we,
    input  palrc_pkg::t_cfg_idx  i_cfg_idx,
    input  palrc_pkg::t_cfg_data i_cfg_data
);
    import palrc_pkg::*;

    `include "phase_angle_level_ramp_control_macros.svh"

    localparam int LW      = $clog2(LEVEL_COUNT + 1);
    localparam int DW_RAW  = $clog2(DELAY_MAX + 1);
    localparam int DW      = (DW_RAW > CFG_DATA_W) ? DW_RAW : CFG_DATA_W;
    localparam int LVL_MID = (LEVEL_COUNT + 1) / 2;

    t_cfg_data         r_cfg [CFG_COUNT];
    logic [LW-1:0]     r_level;
    logic [DW-1:0]     r_delay_now;
    logic              r_plus_seen;
    logic              r_minus_seen;
    logic              r_out_valid;
    t_out              r_out_data;
    logic              r_skid_valid;
    t_out              r_skid_data;

    logic [LW-1:0]     n_level;
    logic [DW-1:0]     n_delay_now;
    logic              n_plus_seen;
    logic              n_minus_seen;
    t_out              n_result;

    logic              push;
    logic              pop;
    logic              fire;
    logic [LW-1:0]     lvl_step;
    logic [DW-1:0]     delay_mid;
    logic [DW-1:0]     target;

    assign o_in_ready  = !r_skid_valid;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;
    assign push        = i_in_valid && o_in_ready;
    assign pop         = r_out_valid && i_out_ready;

    always_comb begin
        n_plus_seen  = r_plus_seen;
        n_minus_seen = r_minus_seen;
        lvl_step     = r_level;
        if (i_in_data.reset_request) begin
            if (!r_plus_seen && r_minus_seen) begin
                n_level = LW'(LEVEL_COUNT);
            end else if (r_plus_seen && !r_minus_seen) begin
                n_level = LW'(1);
            end else begin
                n_level = LW'(LVL_MID);
            end
            delay_mid = '0;
        end else begin
            if (!r_plus_seen && i_in_data.plus_pin && (int'(r_level) < LEVEL_COUNT)) begin
                lvl_step = r_level + LW'(1);
            end
            n_level = lvl_step;
            if (!r_minus_seen && i_in_data.minus_pin && (lvl_step > LW'(1))) begin
                n_level = lvl_step - LW'(1);
            end
            n_plus_seen  = i_in_data.plus_pin;
            n_minus_seen = i_in_data.minus_pin;
            delay_mid    = r_delay_now;
        end
        if (!i_in_data.filter_off) begin
            delay_mid = '0;
        end

        if (int'(n_level) > CFG_COUNT) begin
            target = DW'(r_cfg[CFG_COUNT-1]);
        end else begin
            target = DW'(r_cfg[CFG_IDX_W'(n_level - LW'(1))]);
        end

        fire = i_in_data.zero_cross && i_in_data.filter_off && !i_in_data.power_off;
        n_delay_now = delay_mid;
        if (fire) begin
            if (delay_mid > target) begin
                n_delay_now = delay_mid - DW'(1);
            end else if (delay_mid < target) begin
                n_delay_now = delay_mid + DW'(1);
            end
        end

        n_result.fire          = fire;
        n_result.fire_delay    = fire ? FIRE_DELAY_W'(delay_mid) : '0;
        n_result.speed_level   = SPEED_LEVEL_W'(n_level);
        n_result.level_changed = (n_level != r_level);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < CFG_COUNT; i++) begin
                r_cfg[i] <= CFG_RESET[i];
            end
        end else if (i_cfg_we && (int'(i_cfg_idx) < CFG_COUNT)) begin
            r_cfg[i_cfg_idx] <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level      <= LW'(LEVEL_COUNT);
            r_delay_now  <= DW'(DELAY_MAX);
            r_plus_seen  <= 1'b1;
            r_minus_seen <= 1'b1;
        end else if (push) begin
            r_level      <= n_level;
            r_delay_now  <= n_delay_now;
            r_plus_seen  <= n_plus_seen;
            r_minus_seen <= n_minus_seen;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_out_valid || pop) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= push;
            end
        end else if (push) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_valid || pop) begin
            if (r_skid_valid) begin
                r_out_data <= r_skid_data;
            end else if (push) begin
                r_out_data <= n_result;
            end
        end else if (push) begin
            r_skid_data <= n_result;
        end
    end

    `PALRC_ASSERT_NOW(a_level_range, i_clk, i_rst_n, 1'b1,
        (r_level >= LW'(1)) && (int'(r_level) <= LEVEL_COUNT), "level out of range")
    `PALRC_ASSERT_NOW(a_skid_order, i_clk, i_rst_n, r_skid_valid,
        r_out_valid, "skid stage holds data while output is empty")
    `PALRC_ASSERT_NEXT(a_filter_clear, i_clk, i_rst_n, push && !i_in_data.filter_off,
        r_delay_now == '0, "delay not cleared while filter active")
    `PALRC_ASSERT_NOW(a_idle_delay, i_clk, i_rst_n, r_out_valid && !r_out_data.fire,
        r_out_data.fire_delay == '0, "fire_delay nonzero without fire")

endmodule
